@@ rtl/ccs_pkg.sv @@
`timescale 1ns / 1ps

package ccs_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef enum logic [7:0] {
    MODE_NORMAL = 8'b0000_0001,
    MODE_SLASH  = 8'b0000_0010,
    MODE_LINE   = 8'b0000_0100,
    MODE_BFIRST = 8'b0000_1000,
    MODE_BLOCK  = 8'b0001_0000,
    MODE_BSLASH = 8'b0010_0000,
    MODE_BSTAR  = 8'b0100_0000,
    MODE_ERROR  = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       err;
    logic       done;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t       res0;
    res_t       res1;
    logic [1:0] n_res;
    mode_t      mode_nxt;
    logic       pad_nxt;
  } scan_t;

endpackage

@@ rtl/ccs_scan.sv @@
`timescale 1ns / 1ps

module ccs_scan (
  input  logic [7:0]     in_byte,
  input  logic           eoi,
  input  ccs_pkg::mode_t mode,
  input  logic           pad,
  output ccs_pkg::scan_t scan
);

  function automatic ccs_pkg::res_t mk_res(input logic valid, input logic [7:0] data,
                                           input logic err, input logic done);
    ccs_pkg::res_t r;
    r.data  = valid ? data : 8'h00;
    r.valid = valid;
    r.err   = err;
    r.done  = done;
    r.last  = 1'b0;
    return r;
  endfunction

  ccs_pkg::res_t  r0;
  ccs_pkg::res_t  r1;
  logic [1:0]     n;
  ccs_pkg::mode_t m_nxt;
  logic           p_nxt;
  logic           in_block;
  ccs_pkg::mode_t body_mode;
  logic           body_pad;

  always_comb begin
    if (in_byte == ccs_pkg::CH_NL) begin
      body_mode = ccs_pkg::MODE_BLOCK;
      body_pad  = 1'b1;
    end else if (in_byte == ccs_pkg::CH_SLASH) begin
      body_mode = ccs_pkg::MODE_BSLASH;
      body_pad  = pad;
    end else if (in_byte == ccs_pkg::CH_STAR) begin
      body_mode = ccs_pkg::MODE_BSTAR;
      body_pad  = pad;
    end else begin
      body_mode = ccs_pkg::MODE_BLOCK;
      body_pad  = pad;
    end
  end

  assign in_block = (mode == ccs_pkg::MODE_BFIRST) || (mode == ccs_pkg::MODE_BLOCK) ||
                    (mode == ccs_pkg::MODE_BSLASH) || (mode == ccs_pkg::MODE_BSTAR);

  always_comb begin
    r0    = mk_res(1'b0, 8'h00, 1'b0, 1'b0);
    r1    = mk_res(1'b0, 8'h00, 1'b0, 1'b0);
    n     = 2'd0;
    m_nxt = mode;
    p_nxt = pad;
    if (eoi) begin
      n     = 2'd1;
      m_nxt = ccs_pkg::MODE_NORMAL;
      p_nxt = 1'b0;
      if (mode == ccs_pkg::MODE_SLASH) begin
        r0 = mk_res(1'b1, ccs_pkg::CH_SLASH, 1'b0, 1'b1);
      end else if (in_block && pad) begin
        r0 = mk_res(1'b1, ccs_pkg::CH_NL, 1'b0, 1'b1);
      end else begin
        r0 = mk_res(1'b0, 8'h00, mode == ccs_pkg::MODE_ERROR, 1'b1);
      end
    end else begin
      unique case (mode)
        ccs_pkg::MODE_NORMAL: begin
          if (in_byte == ccs_pkg::CH_SLASH) begin
            m_nxt = ccs_pkg::MODE_SLASH;
          end else begin
            r0 = mk_res(1'b1, in_byte, 1'b0, 1'b0);
            n  = 2'd1;
          end
        end
        ccs_pkg::MODE_SLASH: begin
          if (in_byte == ccs_pkg::CH_STAR) begin
            p_nxt = 1'b0;
            m_nxt = ccs_pkg::MODE_BFIRST;
          end else if (in_byte == ccs_pkg::CH_SLASH) begin
            m_nxt = ccs_pkg::MODE_LINE;
          end else begin
            r0    = mk_res(1'b1, ccs_pkg::CH_SLASH, 1'b0, 1'b0);
            r1    = mk_res(1'b1, in_byte, 1'b0, 1'b0);
            n     = 2'd2;
            m_nxt = ccs_pkg::MODE_NORMAL;
          end
        end
        ccs_pkg::MODE_LINE: begin
          if (in_byte == ccs_pkg::CH_NL) begin
            r0    = mk_res(1'b1, ccs_pkg::CH_NL, 1'b0, 1'b0);
            n     = 2'd1;
            m_nxt = ccs_pkg::MODE_NORMAL;
          end
        end
        ccs_pkg::MODE_BFIRST: begin
          if (in_byte == ccs_pkg::CH_SLASH) begin
            if (pad) begin
              r0 = mk_res(1'b1, ccs_pkg::CH_NL, 1'b0, 1'b0);
              n  = 2'd1;
            end
            p_nxt = 1'b0;
            m_nxt = ccs_pkg::MODE_NORMAL;
          end else begin
            m_nxt = body_mode;
            p_nxt = body_pad;
          end
        end
        ccs_pkg::MODE_BLOCK: begin
          m_nxt = body_mode;
          p_nxt = body_pad;
        end
        ccs_pkg::MODE_BSLASH: begin
          if (in_byte == ccs_pkg::CH_STAR) begin
            r0    = mk_res(1'b0, 8'h00, 1'b1, 1'b0);
            n     = 2'd1;
            m_nxt = ccs_pkg::MODE_ERROR;
          end else begin
            m_nxt = ccs_pkg::MODE_BLOCK;
          end
        end
        ccs_pkg::MODE_BSTAR: begin
          if (in_byte == ccs_pkg::CH_STAR) begin
            m_nxt = ccs_pkg::MODE_BSTAR;
          end else if (in_byte == ccs_pkg::CH_SLASH) begin
            if (pad) begin
              r0 = mk_res(1'b1, ccs_pkg::CH_NL, 1'b0, 1'b0);
              n  = 2'd1;
            end
            p_nxt = 1'b0;
            m_nxt = ccs_pkg::MODE_NORMAL;
          end else begin
            m_nxt = ccs_pkg::MODE_BLOCK;
          end
        end
        ccs_pkg::MODE_ERROR: begin
          m_nxt = ccs_pkg::MODE_ERROR;
        end
        default: begin
          m_nxt = ccs_pkg::MODE_ERROR;
        end
      endcase
    end
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  assign scan.res0     = r0;
  assign scan.res1     = r1;
  assign scan.n_res    = n;
  assign scan.mode_nxt = m_nxt;
  assign scan.pad_nxt  = p_nxt;

endmodule

@@ rtl/c_comment_stripper.sv @@
`timescale 1ns / 1ps
// C comment stripper: takes C source one byte per request and passes it on
// with line and block comments removed.
// Input channel: in_tdata[7:0] carries the source byte, in_tlast marks end of
// input (the byte is then ignored; pending output is flushed and the scanner
// returns to its reset state).
// Result channel: out_tdata[7:0] carries the kept byte, out_tuser carries
// byte_valid, nested_error and stream_done, out_tlast marks the last result
// caused by one input request. An input byte yields zero, one or two results.
// An accepted byte is held in an input register and scanned from there; its
// first result is then written to the output register once that register is
// free. Throughput: one byte per cycle while the receiver keeps up; a byte that
// yields two results holds the scanner until its second result is in out_r.
// The input register and the output register with its second-result slot
// decouple the two sides: a stalled receiver fills them, then in_tready drops.
// Reset (rst_n low, synchronous) empties all stages and returns the scanner
// to normal mode with no newline pending.

module c_comment_stripper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [0] byte_valid, [1] nested_error, [2] stream_done
  output logic       out_tlast
);

  logic           in_valid_r;
  logic [7:0]     in_byte_r;
  logic           in_eoi_r;
  ccs_pkg::mode_t mode_r;
  logic           pad_r;
  logic           out_valid_r;
  ccs_pkg::res_t  out_r;
  logic           pend_valid_r;
  ccs_pkg::res_t  pend_r;
  ccs_pkg::scan_t scan;
  logic           advance;

  ccs_scan u_scan (
    .in_byte (in_byte_r),
    .eoi     (in_eoi_r),
    .mode    (mode_r),
    .pad     (pad_r),
    .scan    (scan)
  );

  assign advance   = in_valid_r && !pend_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r <= in_tdata;
      in_eoi_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ccs_pkg::MODE_NORMAL;
      pad_r  <= 1'b0;
    end else if (advance) begin
      mode_r <= scan.mode_nxt;
      pad_r  <= scan.pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (pend_valid_r) begin
      if (out_tready) begin
        pend_valid_r <= 1'b0;
      end
    end else if (advance && (scan.n_res != 2'd0)) begin
      out_valid_r  <= 1'b1;
      pend_valid_r <= (scan.n_res == 2'd2);
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid_r) begin
      if (out_tready) begin
        out_r <= pend_r;
      end
    end else if (advance && (scan.n_res != 2'd0)) begin
      out_r  <= scan.res0;
      pend_r <= scan.res1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.data;
  assign out_tuser  = {out_r.done, out_r.err, out_r.valid};
  assign out_tlast  = out_r.last;

endmodule
